[sv/dcpa_pkg.sv]
// Shared types and constants for the dirty-channel priority arbiter.
// Holds the microcode control word, condition flags and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package dcpa_pkg;

    // Block dimensions
    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int CHUNK_BYTES  = 131;
    localparam int STORE_BYTES  = 4096;   // power of two: modulo is a mask
    localparam int OFF_W        = 12;
    localparam int CNT_W        = 8;
    localparam int SEQ_W        = 8;
    localparam int PRIO_W       = 8;
    localparam int ROUND_W      = 5;
    localparam int MAX_ROUNDS   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int PC_W         = 4;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MARK = 2'd1,
        OP_ARM  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PPT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESULTS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SENDABLE = 3'd4;

    typedef logic [PC_W-1:0] pc_t;

    // Microprogram step addresses
    localparam pc_t PC_IDLE      = 4'd0;
    localparam pc_t PC_INIT      = 4'd1;
    localparam pc_t PC_ROUND_TOP = 4'd2;
    localparam pc_t PC_SCAN      = 4'd3;
    localparam pc_t PC_DECIDE    = 4'd4;
    localparam pc_t PC_SPILL     = 4'd5;
    localparam pc_t PC_GRANT     = 4'd6;
    localparam pc_t PC_ROUND_END = 4'd7;
    localparam pc_t PC_FLUSH     = 4'd8;

    // Datapath actions
    typedef enum logic [3:0] {
        ACT_NOP       = 4'd0,
        ACT_ACCEPT    = 4'd1,
        ACT_LOAD_RND  = 4'd2,
        ACT_SCAN_CLR  = 4'd3,
        ACT_SCAN      = 4'd4,
        ACT_SPILL     = 4'd5,
        ACT_GRANT     = 4'd6,
        ACT_ROUND_DEC = 4'd7,
        ACT_FLUSH     = 4'd8
    } act_t;

    // Jump conditions
    typedef enum logic [2:0] {
        CND_NEVER    = 3'd0,
        CND_TICK_GO  = 3'd1,
        CND_RND_DONE = 3'd2,
        CND_SCAN_ON  = 3'd3,
        CND_NO_GRANT = 3'd4
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        logic  wait_out;
        pc_t   jmp;
        pc_t   nxt;
    } ctrl_word_t;

    typedef struct packed {
        logic tick_go;
        logic rnd_done;
        logic scan_on;
        logic no_grant;
        logic stall;
    } flags_t;

endpackage

[sv/dirty_channel_priority_arbiter_unit.sv]
// Top level of the dirty-channel priority arbiter: registers, datapath and ports.
// Depends on dcpa_pkg and on the sequencer dcpa_useq.
`timescale 1ns / 1ps

// A tick with link_ready set runs min(packets_per_tick, 16) rounds under the
// microcode sequencer. Each round clears the scan, scans the channels one per
// cycle and decides; on a grant it moves the held grant out and loads the new
// one, and then it counts the round down. Around the rounds a tick also runs
// the accept, set-up, closing round check and final flush steps.
// One grant is held back until the next grant or the end of the tick so that
// last can be marked; a stalled result port stalls the sequencer only when a
// held grant has to move out. The block takes a new input beat only between
// ticks. Configuration beats are taken in any cycle (cfg_ready is always high).

module dirty_channel_priority_arbiter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcpa_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_operation,
    input  logic                              s_link_ready,
    input  logic [dcpa_pkg::CH_W-1:0]         s_channel,
    input  logic [dcpa_pkg::CNT_W-1:0]        s_packet_count,
    input  logic [dcpa_pkg::OFF_W-1:0]        s_start_offset,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dcpa_pkg::CH_W-1:0]         m_granted_channel,
    output logic [dcpa_pkg::SEQ_W-1:0]        m_sequence_res,
    output logic [dcpa_pkg::OFF_W-1:0]        m_read_offset,
    output logic [dcpa_pkg::CNT_W-1:0]        m_remaining,
    output logic                              m_last
);

    localparam int NCH = dcpa_pkg::NUM_CHANNELS;
    localparam logic [dcpa_pkg::CH_W-1:0] CH_LAST = dcpa_pkg::CH_W'(NCH - 1);
    localparam logic [dcpa_pkg::OFF_W:0] CHUNK_ADD = (dcpa_pkg::OFF_W + 1)'(dcpa_pkg::CHUNK_BYTES);
    localparam logic [dcpa_pkg::OFF_W:0] STORE_MASK = (dcpa_pkg::OFF_W + 1)'(dcpa_pkg::STORE_BYTES - 1);

    dcpa_pkg::ctrl_word_t cw;
    dcpa_pkg::flags_t     flags;

    // Configuration registers
    logic [NCH-1:0]                   active_reg;
    logic [dcpa_pkg::CFG_DATA_W-1:0]  prio_reg;
    logic [dcpa_pkg::ROUND_W-1:0]     ppt_reg;
    logic [dcpa_pkg::CH_W-1:0]        results_ch_reg;
    logic [NCH-1:0]                   sendable_reg;

    // Arbiter state
    logic [NCH-1:0]                   pending_reg;
    logic [dcpa_pkg::SEQ_W-1:0]       seq_reg [NCH];
    logic [dcpa_pkg::OFF_W-1:0]       res_off_reg;
    logic [dcpa_pkg::CNT_W-1:0]       res_left_reg;

    // Round and scan working registers
    logic [dcpa_pkg::ROUND_W-1:0]     round_cnt_reg;
    logic [dcpa_pkg::CH_W-1:0]        scan_ch_reg;
    logic [dcpa_pkg::CH_W-1:0]        best_reg;
    logic [dcpa_pkg::PRIO_W-1:0]      bestp_reg;

    // Held grant and output stage
    logic                             hold_valid_reg;
    logic [dcpa_pkg::CH_W-1:0]        hold_ch_reg;
    logic [dcpa_pkg::SEQ_W-1:0]       hold_seq_reg;
    logic [dcpa_pkg::OFF_W-1:0]       hold_off_reg;
    logic [dcpa_pkg::CNT_W-1:0]       hold_rem_reg;
    logic                             m_valid_reg;
    logic [dcpa_pkg::CH_W-1:0]        out_ch_reg;
    logic [dcpa_pkg::SEQ_W-1:0]       out_seq_reg;
    logic [dcpa_pkg::OFF_W-1:0]       out_off_reg;
    logic [dcpa_pkg::CNT_W-1:0]       out_rem_reg;
    logic                             out_last_reg;

    logic                             in_beat;
    logic                             out_free;
    logic                             move_out;
    logic [dcpa_pkg::PRIO_W-1:0]      scan_prio;
    logic                             best_is_res;
    logic [dcpa_pkg::CNT_W-1:0]       left_dec;
    logic [dcpa_pkg::OFF_W:0]         off_sum;
    logic [dcpa_pkg::OFF_W-1:0]       off_next;
    logic [dcpa_pkg::ROUND_W-1:0]     rounds_sat;

    dcpa_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .cw      (cw)
    );

    // Handshake and datapath helpers
    assign cfg_ready   = 1'b1;
    assign s_ready     = (cw.act == dcpa_pkg::ACT_ACCEPT);
    assign in_beat     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign move_out    = ((cw.act == dcpa_pkg::ACT_SPILL) || (cw.act == dcpa_pkg::ACT_FLUSH))
                         && hold_valid_reg && out_free;
    assign scan_prio   = prio_reg[scan_ch_reg * dcpa_pkg::PRIO_W +: dcpa_pkg::PRIO_W];
    assign best_is_res = (best_reg == results_ch_reg);
    assign left_dec    = res_left_reg - 1'b1;
    assign off_sum     = {1'b0, res_off_reg} + CHUNK_ADD;
    assign off_next    = dcpa_pkg::OFF_W'(off_sum & STORE_MASK);
    assign rounds_sat  = (ppt_reg > dcpa_pkg::ROUND_W'(dcpa_pkg::MAX_ROUNDS))
                         ? dcpa_pkg::ROUND_W'(dcpa_pkg::MAX_ROUNDS) : ppt_reg;

    // Condition flags for the sequencer
    always_comb begin
        flags.tick_go  = in_beat && (s_operation == dcpa_pkg::OP_TICK) && s_link_ready;
        flags.rnd_done = (round_cnt_reg == '0);
        flags.scan_on  = (scan_ch_reg != CH_LAST);
        flags.no_grant = (bestp_reg == '0) || !sendable_reg[best_reg]
                         || (best_is_res && (res_left_reg == '0));
        flags.stall    = hold_valid_reg && !out_free;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= '0;
            prio_reg       <= '0;
            ppt_reg        <= dcpa_pkg::ROUND_W'(1);
            results_ch_reg <= CH_LAST;
            sendable_reg   <= '1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dcpa_pkg::REG_ACTIVE:   active_reg     <= cfg_data[NCH-1:0];
                dcpa_pkg::REG_PRIO:     prio_reg       <= cfg_data;
                dcpa_pkg::REG_PPT:      ppt_reg        <= cfg_data[dcpa_pkg::ROUND_W-1:0];
                dcpa_pkg::REG_RESULTS:  results_ch_reg <= cfg_data[dcpa_pkg::CH_W-1:0];
                dcpa_pkg::REG_SENDABLE: sendable_reg   <= cfg_data[NCH-1:0];
                default: ;
            endcase
        end
    end

    // Arbiter state: marks, arms and grants
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg    <= '0;
            res_off_reg    <= '0;
            res_left_reg   <= '0;
            round_cnt_reg  <= '0;
            hold_valid_reg <= 1'b0;
            for (int i = 0; i < NCH; i++) begin
                seq_reg[i] <= '0;
            end
        end else begin
            case (cw.act)
                dcpa_pkg::ACT_ACCEPT: begin
                    if (in_beat && (s_operation == dcpa_pkg::OP_MARK)
                        && ({1'b0, s_channel} < (dcpa_pkg::CH_W + 1)'(NCH))) begin
                        pending_reg[s_channel] <= 1'b1;
                    end
                    if (in_beat && (s_operation == dcpa_pkg::OP_ARM)) begin
                        res_left_reg <= s_packet_count;
                        res_off_reg  <= s_start_offset;
                    end
                end
                dcpa_pkg::ACT_LOAD_RND: begin
                    round_cnt_reg <= rounds_sat;
                end
                dcpa_pkg::ACT_ROUND_DEC: begin
                    round_cnt_reg <= round_cnt_reg - 1'b1;
                end
                dcpa_pkg::ACT_SPILL, dcpa_pkg::ACT_FLUSH: begin
                    if (move_out) begin
                        hold_valid_reg <= 1'b0;
                    end
                end
                dcpa_pkg::ACT_GRANT: begin
                    hold_valid_reg    <= 1'b1;
                    seq_reg[best_reg] <= seq_reg[best_reg] + 1'b1;
                    if (best_is_res) begin
                        res_off_reg  <= off_next;
                        res_left_reg <= left_dec;
                        if (left_dec == '0) begin
                            pending_reg[best_reg] <= 1'b0;
                        end
                    end else begin
                        pending_reg[best_reg] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Scan one channel per step; keep the first highest priority
    always_ff @(posedge aclk) begin
        if (cw.act == dcpa_pkg::ACT_SCAN_CLR) begin
            scan_ch_reg <= '0;
            best_reg    <= '0;
            bestp_reg   <= '0;
        end else if (cw.act == dcpa_pkg::ACT_SCAN) begin
            scan_ch_reg <= scan_ch_reg + 1'b1;
            if (active_reg[scan_ch_reg] && pending_reg[scan_ch_reg]
                && (scan_prio > bestp_reg)) begin
                best_reg  <= scan_ch_reg;
                bestp_reg <= scan_prio;
            end
        end
    end

    // Load the held grant
    always_ff @(posedge aclk) begin
        if (cw.act == dcpa_pkg::ACT_GRANT) begin
            hold_ch_reg  <= best_reg;
            hold_seq_reg <= seq_reg[best_reg];
            hold_off_reg <= best_is_res ? res_off_reg : '0;
            hold_rem_reg <= best_is_res ? left_dec : '0;
        end
    end

    // Output stage: drop on a taken beat, refill from the held grant
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (move_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move_out) begin
            out_ch_reg   <= hold_ch_reg;
            out_seq_reg  <= hold_seq_reg;
            out_off_reg  <= hold_off_reg;
            out_rem_reg  <= hold_rem_reg;
            out_last_reg <= (cw.act == dcpa_pkg::ACT_FLUSH);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_granted_channel = out_ch_reg;
    assign m_sequence_res    = out_seq_reg;
    assign m_read_offset     = out_off_reg;
    assign m_remaining       = out_rem_reg;
    assign m_last            = out_last_reg;

`ifndef NO_ASSERTIONS
    // Nothing is held back while the block waits for a new beat
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !hold_valid_reg)
        else $error("grant still held while accepting input");

    // A grant step always leaves a held grant behind
    a_grant_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.act == dcpa_pkg::ACT_GRANT) |=> hold_valid_reg)
        else $error("grant step did not load the hold stage");

    // Only a nonzero-priority winner is granted
    a_grant_prio: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.act == dcpa_pkg::ACT_GRANT) |-> (bestp_reg != '0))
        else $error("grant issued with zero priority");

    // Round count never exceeds the saturation limit
    a_round_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        round_cnt_reg <= dcpa_pkg::ROUND_W'(dcpa_pkg::MAX_ROUNDS))
        else $error("round counter above limit");
`endif

endmodule

[sv/dcpa_useq.sv]
// Microcode sequencer for the arbiter: step counter, control store and jump logic.
// Depends on dcpa_pkg for the control word, flags and step addresses.
`timescale 1ns / 1ps

module dcpa_useq (
    input  logic                aclk,
    input  logic                aresetn,
    input  dcpa_pkg::flags_t    flags,
    output dcpa_pkg::ctrl_word_t cw
);

    dcpa_pkg::pc_t pc_reg;
    dcpa_pkg::pc_t pc_next;
    logic          take_jump;

    // Control store: one word per step
    always_comb begin
        cw = '{act: dcpa_pkg::ACT_NOP, cond: dcpa_pkg::CND_NEVER, wait_out: 1'b0,
               jmp: dcpa_pkg::PC_IDLE, nxt: dcpa_pkg::PC_IDLE};
        case (pc_reg)
            dcpa_pkg::PC_IDLE: begin
                cw = '{act: dcpa_pkg::ACT_ACCEPT, cond: dcpa_pkg::CND_TICK_GO,
                       wait_out: 1'b0, jmp: dcpa_pkg::PC_INIT, nxt: dcpa_pkg::PC_IDLE};
            end
            dcpa_pkg::PC_INIT: begin
                cw = '{act: dcpa_pkg::ACT_LOAD_RND, cond: dcpa_pkg::CND_NEVER,
                       wait_out: 1'b0, jmp: dcpa_pkg::PC_IDLE,
                       nxt: dcpa_pkg::PC_ROUND_TOP};
            end
            dcpa_pkg::PC_ROUND_TOP: begin
                cw = '{act: dcpa_pkg::ACT_SCAN_CLR, cond: dcpa_pkg::CND_RND_DONE,
                       wait_out: 1'b0, jmp: dcpa_pkg::PC_FLUSH, nxt: dcpa_pkg::PC_SCAN};
            end
            dcpa_pkg::PC_SCAN: begin
                cw = '{act: dcpa_pkg::ACT_SCAN, cond: dcpa_pkg::CND_SCAN_ON,
                       wait_out: 1'b0, jmp: dcpa_pkg::PC_SCAN, nxt: dcpa_pkg::PC_DECIDE};
            end
            dcpa_pkg::PC_DECIDE: begin
                cw = '{act: dcpa_pkg::ACT_NOP, cond: dcpa_pkg::CND_NO_GRANT,
                       wait_out: 1'b0, jmp: dcpa_pkg::PC_ROUND_END,
                       nxt: dcpa_pkg::PC_SPILL};
            end
            dcpa_pkg::PC_SPILL: begin
                cw = '{act: dcpa_pkg::ACT_SPILL, cond: dcpa_pkg::CND_NEVER,
                       wait_out: 1'b1, jmp: dcpa_pkg::PC_IDLE, nxt: dcpa_pkg::PC_GRANT};
            end
            dcpa_pkg::PC_GRANT: begin
                cw = '{act: dcpa_pkg::ACT_GRANT, cond: dcpa_pkg::CND_NEVER,
                       wait_out: 1'b0, jmp: dcpa_pkg::PC_IDLE,
                       nxt: dcpa_pkg::PC_ROUND_END};
            end
            dcpa_pkg::PC_ROUND_END: begin
                cw = '{act: dcpa_pkg::ACT_ROUND_DEC, cond: dcpa_pkg::CND_NEVER,
                       wait_out: 1'b0, jmp: dcpa_pkg::PC_IDLE,
                       nxt: dcpa_pkg::PC_ROUND_TOP};
            end
            dcpa_pkg::PC_FLUSH: begin
                cw = '{act: dcpa_pkg::ACT_FLUSH, cond: dcpa_pkg::CND_NEVER,
                       wait_out: 1'b1, jmp: dcpa_pkg::PC_IDLE, nxt: dcpa_pkg::PC_IDLE};
            end
            default: begin
                cw = '{act: dcpa_pkg::ACT_NOP, cond: dcpa_pkg::CND_NEVER,
                       wait_out: 1'b0, jmp: dcpa_pkg::PC_IDLE, nxt: dcpa_pkg::PC_IDLE};
            end
        endcase
    end

    // Evaluate the jump condition of the current word
    always_comb begin
        case (cw.cond)
            dcpa_pkg::CND_NEVER:    take_jump = 1'b0;
            dcpa_pkg::CND_TICK_GO:  take_jump = flags.tick_go;
            dcpa_pkg::CND_RND_DONE: take_jump = flags.rnd_done;
            dcpa_pkg::CND_SCAN_ON:  take_jump = flags.scan_on;
            dcpa_pkg::CND_NO_GRANT: take_jump = flags.no_grant;
            default:                take_jump = 1'b0;
        endcase
    end

    // Hold on a stalled step, else jump or advance
    always_comb begin
        if (cw.wait_out && flags.stall) begin
            pc_next = pc_reg;
        end else if (take_jump) begin
            pc_next = cw.jmp;
        end else begin
            pc_next = cw.nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= dcpa_pkg::PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[tb/sv/dirty_channel_priority_arbiter_unit_tb.sv]
// Self-checking testbench for the dirty-channel priority arbiter.
// Drives mark, arm and tick beats, predicts every grant and checks each result beat.
// Depends on dcpa_pkg and dirty_channel_priority_arbiter_unit.
`timescale 1ns / 1ps

module dirty_channel_priority_arbiter_unit_tb;

    localparam int                              SETTLE_CYCLES = 300;
    localparam int                              HOLD_CYCLES   = 600;
    localparam int                              IDLE_PCT      = 32;
    localparam longint                          TIMEOUT_NS    = 64'd12_000_000;
    localparam logic [dcpa_pkg::CFG_IDX_W-1:0]  REG_SPARE     = 3'd7;

    typedef struct packed {
        dcpa_pkg::op_t                op;
        logic                         link;
        logic [dcpa_pkg::CH_W-1:0]    ch;
        logic [dcpa_pkg::CNT_W-1:0]   cnt;
        logic [dcpa_pkg::OFF_W-1:0]   off;
    } cmd_t;

    typedef struct packed {
        logic [dcpa_pkg::CH_W-1:0]    ch;
        logic [dcpa_pkg::SEQ_W-1:0]   seq;
        logic [dcpa_pkg::OFF_W-1:0]   off;
        logic [dcpa_pkg::CNT_W-1:0]   left;
        logic                         last;
    } grant_t;

    logic                            aclk           = 1'b0;
    logic                            aresetn        = 1'b0;
    logic                            cfg_valid      = 1'b0;
    logic                            cfg_ready;
    logic [dcpa_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [dcpa_pkg::CFG_DATA_W-1:0] cfg_data       = '0;
    logic                            s_valid        = 1'b0;
    logic                            s_ready;
    logic [1:0]                      s_operation    = '0;
    logic                            s_link_ready   = 1'b0;
    logic [dcpa_pkg::CH_W-1:0]       s_channel      = '0;
    logic [dcpa_pkg::CNT_W-1:0]      s_packet_count = '0;
    logic [dcpa_pkg::OFF_W-1:0]      s_start_offset = '0;
    logic                            m_valid;
    logic                            m_ready        = 1'b0;
    logic [dcpa_pkg::CH_W-1:0]       m_granted_channel;
    logic [dcpa_pkg::SEQ_W-1:0]      m_sequence_res;
    logic [dcpa_pkg::OFF_W-1:0]      m_read_offset;
    logic [dcpa_pkg::CNT_W-1:0]      m_remaining;
    logic                            m_last;

    // Predicted copy of the register file
    logic [7:0]                      cfg_active = 8'h00;
    logic [63:0]                     cfg_prio   = 64'h0;
    logic [dcpa_pkg::ROUND_W-1:0]    cfg_ppt    = 5'd1;
    logic [dcpa_pkg::CH_W-1:0]       cfg_res_ch = 3'd7;
    logic [7:0]                      cfg_send   = 8'hFF;

    // Predicted arbiter state
    logic [7:0]                      pend     = 8'h00;
    logic [dcpa_pkg::SEQ_W-1:0]      seq_num [dcpa_pkg::NUM_CHANNELS];
    logic [dcpa_pkg::OFF_W-1:0]      res_off  = '0;
    logic [dcpa_pkg::CNT_W-1:0]      res_left = '0;

    cmd_t                  cmd_q [$];
    grant_t                grant_q [$];
    int                    mismatches = 0;
    bit                    s_taken    = 1'b0;
    bit                    quiet      = 1'b0;
    bit                    hold_req   = 1'b0;
    int                    hold_left  = 0;

    dirty_channel_priority_arbiter_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_link_ready      (s_link_ready),
        .s_channel         (s_channel),
        .s_packet_count    (s_packet_count),
        .s_start_offset    (s_start_offset),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_channel (m_granted_channel),
        .m_sequence_res    (m_sequence_res),
        .m_read_offset     (m_read_offset),
        .m_remaining       (m_remaining),
        .m_last            (m_last)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Work out the grants one accepted beat causes and queue them
    task automatic predict_grants(input cmd_t cmd);
        grant_t      burst [dcpa_pkg::MAX_ROUNDS];
        int          n;
        int          rounds;
        int          r;
        int          c;
        int          best;
        logic [7:0]  bestp;
        n = 0;
        case (cmd.op)
            dcpa_pkg::OP_MARK: pend[cmd.ch] = 1'b1;
            dcpa_pkg::OP_ARM: begin
                res_left = cmd.cnt;
                res_off  = cmd.off;
            end
            dcpa_pkg::OP_TICK: begin
                if (cmd.link) begin
                    rounds = (cfg_ppt > dcpa_pkg::MAX_ROUNDS) ? dcpa_pkg::MAX_ROUNDS
                                                             : cfg_ppt;
                    for (r = 0; r < rounds; r++) begin
                        // highest nonzero priority wins, lowest index on a tie
                        best  = 0;
                        bestp = 8'd0;
                        for (c = 0; c < dcpa_pkg::NUM_CHANNELS; c++) begin
                            if (cfg_active[c] && pend[c] && cfg_prio[8*c +: 8] > bestp) begin
                                best  = c;
                                bestp = cfg_prio[8*c +: 8];
                            end
                        end
                        // an unsendable winner or an empty results channel burns the round
                        if (bestp != 8'd0 && cfg_send[best]
                                && (best != cfg_res_ch || res_left != 0)) begin
                            burst[n].ch   = best[dcpa_pkg::CH_W-1:0];
                            burst[n].seq  = seq_num[best];
                            burst[n].off  = '0;
                            burst[n].left = '0;
                            burst[n].last = 1'b0;
                            seq_num[best] = seq_num[best] + 1'b1;
                            if (best == cfg_res_ch) begin
                                burst[n].off  = res_off;
                                res_off       = dcpa_pkg::OFF_W'((res_off + dcpa_pkg::CHUNK_BYTES)
                                                                 % dcpa_pkg::STORE_BYTES);
                                res_left      = res_left - 1'b1;
                                burst[n].left = res_left;
                                if (res_left == 0)
                                    pend[best] = 1'b0;
                            end else begin
                                pend[best] = 1'b0;
                            end
                            n++;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (n > 0)
            burst[n-1].last = 1'b1;
        for (r = 0; r < n; r++)
            grant_q.push_back(burst[r]);
    endtask

    task automatic check_field(input string name, input logic [dcpa_pkg::OFF_W-1:0] want,
                               input logic [dcpa_pkg::OFF_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Score result beats against the oldest prediction, then predict from input beats
    always @(posedge aclk) begin : scoreboard
        grant_t want;
        if (aresetn && m_valid && m_ready) begin
            if (grant_q.size() == 0) begin
                $error("granted_channel: expected no beat, got %0d", m_granted_channel);
                mismatches++;
            end else begin
                want = grant_q.pop_front();
                check_field("granted_channel", dcpa_pkg::OFF_W'(want.ch),
                            dcpa_pkg::OFF_W'(m_granted_channel));
                check_field("sequence_res", dcpa_pkg::OFF_W'(want.seq),
                            dcpa_pkg::OFF_W'(m_sequence_res));
                check_field("read_offset", want.off, m_read_offset);
                check_field("remaining", dcpa_pkg::OFF_W'(want.left),
                            dcpa_pkg::OFF_W'(m_remaining));
                check_field("last", dcpa_pkg::OFF_W'(want.last), dcpa_pkg::OFF_W'(m_last));
            end
        end
        s_taken = aresetn && s_valid && s_ready;
        if (s_taken)
            predict_grants(cmd_t'({dcpa_pkg::op_t'(s_operation), s_link_ready, s_channel,
                                   s_packet_count, s_start_offset}));
    end

    // Offer pending beats, with random gaps
    always @(negedge aclk) begin : driver
        cmd_t cmd;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (cmd_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                cmd = cmd_q.pop_front();
                s_valid        <= 1'b1;
                s_operation    <= cmd.op;
                s_link_ready   <= cmd.link;
                s_channel      <= cmd.ch;
                s_packet_count <= cmd.cnt;
                s_start_offset <= cmd.off;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Accept result beats, with random stalls and one long hold-off on request
    always @(negedge aclk) begin : receiver
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic push_cmd(input dcpa_pkg::op_t op, input logic link,
                            input logic [dcpa_pkg::CH_W-1:0] ch,
                            input logic [dcpa_pkg::CNT_W-1:0] cnt,
                            input logic [dcpa_pkg::OFF_W-1:0] off);
        cmd_t cmd;
        cmd.op   = op;
        cmd.link = link;
        cmd.ch   = ch;
        cmd.cnt  = cnt;
        cmd.off  = off;
        cmd_q.push_back(cmd);
    endtask

    // Mostly mark-then-tick sequences with random content, some dropped beats
    task automatic queue_traffic(input int target);
        int                         made;
        int                         roll;
        int                         marks;
        logic [dcpa_pkg::CNT_W-1:0] cnt;
        made = 0;
        while (made < target) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                push_cmd(dcpa_pkg::OP_NONE, 1'($urandom_range(1)),
                         dcpa_pkg::CH_W'($urandom_range(7)),
                         dcpa_pkg::CNT_W'($urandom_range(255)),
                         dcpa_pkg::OFF_W'($urandom_range(4095)));
            end else if (roll < 10) begin
                push_cmd(dcpa_pkg::OP_TICK, 1'b0, dcpa_pkg::CH_W'($urandom_range(7)),
                         dcpa_pkg::CNT_W'($urandom_range(255)),
                         dcpa_pkg::OFF_W'($urandom_range(4095)));
            end else begin
                marks = $urandom_range(1, 3);
                repeat (marks)
                    push_cmd(dcpa_pkg::OP_MARK, 1'($urandom_range(1)),
                             dcpa_pkg::CH_W'($urandom_range(7)),
                             dcpa_pkg::CNT_W'($urandom_range(255)),
                             dcpa_pkg::OFF_W'($urandom_range(4095)));
                made += marks;
                if ($urandom_range(99) < 30) begin
                    roll = $urandom_range(99);
                    if (roll < 70)
                        cnt = dcpa_pkg::CNT_W'($urandom_range(1, 12));
                    else if (roll < 85)
                        cnt = 8'd0;
                    else
                        cnt = dcpa_pkg::CNT_W'($urandom_range(200, 255));
                    push_cmd(dcpa_pkg::OP_ARM, 1'($urandom_range(1)),
                             dcpa_pkg::CH_W'($urandom_range(7)), cnt,
                             dcpa_pkg::OFF_W'($urandom_range(4095)));
                    made++;
                end
                push_cmd(dcpa_pkg::OP_TICK, 1'b1, dcpa_pkg::CH_W'($urandom_range(7)),
                         dcpa_pkg::CNT_W'($urandom_range(255)),
                         dcpa_pkg::OFF_W'($urandom_range(4095)));
                made++;
            end
        end
    endtask

    task automatic write_reg(input logic [dcpa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            dcpa_pkg::REG_ACTIVE:   cfg_active = val[7:0];
            dcpa_pkg::REG_PRIO:     cfg_prio   = val;
            dcpa_pkg::REG_PPT:      cfg_ppt    = val[dcpa_pkg::ROUND_W-1:0];
            dcpa_pkg::REG_RESULTS:  cfg_res_ch = val[dcpa_pkg::CH_W-1:0];
            dcpa_pkg::REG_SENDABLE: cfg_send   = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [63:0] active, input logic [63:0] prio,
                              input logic [63:0] ppt, input logic [63:0] res_ch,
                              input logic [63:0] send);
        write_reg(dcpa_pkg::REG_ACTIVE, active);
        write_reg(dcpa_pkg::REG_PRIO, prio);
        write_reg(dcpa_pkg::REG_PPT, ppt);
        write_reg(dcpa_pkg::REG_RESULTS, res_ch);
        write_reg(dcpa_pkg::REG_SENDABLE, send);
    endtask

    // Wait for every beat to go in and every grant to come out, then let the block settle
    task automatic drain_phase();
        while (cmd_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (grant_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES)
            @(posedge aclk);
    endtask

    initial begin : main
        for (int i = 0; i < dcpa_pkg::NUM_CHANNELS; i++)
            seq_num[i] = '0;
        repeat (9)
            @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: nothing is active, so a tick grants nothing
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd0, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_TICK, 1'b1, 3'd0, 8'd0, 12'd0);
        drain_phase();

        // Directed: empty tick, link down, tie on priority, priority zero,
        // offset wrap, count running out, empty results channel, unknown code
        set_config(64'hFF, 64'h01FF_0203_0005_0508, 64'd4, 64'd7, 64'hFF);
        push_cmd(dcpa_pkg::OP_TICK, 1'b1, 3'd7, 8'hFF, 12'hFFF);
        push_cmd(dcpa_pkg::OP_TICK, 1'b0, 3'd0, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd0, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd1, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_MARK, 1'b1, 3'd2, 8'hFF, 12'hFFF);
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd3, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd6, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_ARM, 1'b0, 3'd0, 8'd3, 12'hFFF);
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd7, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_TICK, 1'b1, 3'd0, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_TICK, 1'b1, 3'd0, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_TICK, 1'b1, 3'd0, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd7, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_TICK, 1'b1, 3'd0, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_NONE, 1'b1, 3'd5, 8'hA5, 12'h5A5);
        drain_phase();

        // Directed: round count saturates, unsendable winner keeps its pending bit
        set_config(64'hFE, 64'h01FF_0203_0005_0508, 64'd31, 64'd6, 64'hBF);
        write_reg(REG_SPARE, {$urandom, $urandom});
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd6, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd0, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd5, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_ARM, 1'b0, 3'd0, 8'd2, 12'd100);
        push_cmd(dcpa_pkg::OP_TICK, 1'b1, 3'd0, 8'd0, 12'd0);
        drain_phase();

        // Full rounds under a long receiver hold-off so the input backs up
        set_config(64'hFF, {$urandom, $urandom}, 64'd16, 64'($urandom_range(7)), 64'hFF);
        hold_req = 1'b1;
        queue_traffic(24);
        drain_phase();

        // Fully random register contents, spare upper bits included
        set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
        queue_traffic(24);
        drain_phase();

        // Zero rounds, nothing sendable
        set_config(64'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 64'h00);
        queue_traffic(6);
        drain_phase();

        // All priorities tied: results channel 0 always wins, run its sequence past a wrap
        set_config(64'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd16, 64'd0, 64'hFF);
        quiet = 1'b1;
        push_cmd(dcpa_pkg::OP_ARM, 1'b0, 3'd0, 8'hFF, 12'hFFF);
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd0, 8'd0, 12'd0);
        repeat (16)
            push_cmd(dcpa_pkg::OP_TICK, 1'b1, 3'd0, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_ARM, 1'b0, 3'd0, 8'd8, 12'd0);
        push_cmd(dcpa_pkg::OP_MARK, 1'b0, 3'd0, 8'd0, 12'd0);
        push_cmd(dcpa_pkg::OP_TICK, 1'b1, 3'd0, 8'd0, 12'd0);
        drain_phase();
        quiet = 1'b0;
        queue_traffic(18);
        drain_phase();

        // Nothing active, no priorities
        set_config(64'h00, 64'h0, 64'd1, 64'd7, 64'hFF);
        queue_traffic(6);
        drain_phase();

        if (mismatches == 0 && grant_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
